>>> rtl/hrgd_pkg.sv
// Package with HID usage codes, key codes and shared types of the gesture decoder.
`timescale 1ns / 1ps

package hrgd_pkg;

  // HID usage pages
  localparam logic [15:0] PAGE_DESKTOP   = 16'h0001;
  localparam logic [15:0] PAGE_BUTTON    = 16'h0009;
  localparam logic [15:0] PAGE_CONSUMER  = 16'h000C;
  localparam logic [15:0] PAGE_DIGITIZER = 16'h000D;

  // HID usages within those pages
  localparam logic [15:0] DESK_X        = 16'h0030;
  localparam logic [15:0] DESK_Y        = 16'h0031;
  localparam logic [15:0] BTN_PRIMARY   = 16'h0001;
  localparam logic [15:0] DIG_TIP       = 16'h0042;
  localparam logic [15:0] DIG_IN_RANGE  = 16'h0032;
  localparam logic [15:0] CONS_VOL_UP   = 16'h00E9;
  localparam logic [15:0] CONS_VOL_DOWN = 16'h00EA;

  // Key codes
  localparam logic [2:0] KC_BUTTON  = 3'd0;
  localparam logic [2:0] KC_UP      = 3'd1;
  localparam logic [2:0] KC_DOWN    = 3'd2;
  localparam logic [2:0] KC_LEFT    = 3'd3;
  localparam logic [2:0] KC_RIGHT   = 3'd4;
  localparam logic [2:0] KC_UNKNOWN = 3'd5;
  localparam logic [2:0] KC_SHUTTER = 3'd6;

  localparam logic [23:0] DEBOUNCE_RESET = 24'd150000;
  localparam logic [1:0]  SEEN_MAX       = 2'd2;

  // Tracked history of one coordinate axis
  typedef struct packed {
    logic signed [31:0] previous;
    logic signed [31:0] latest;
    logic [1:0]         seen;
  } axis_t;

endpackage

>>> rtl/hrgd_direction.sv
// Swipe direction decision from the tracked X and Y axis history.
`timescale 1ns / 1ps

module hrgd_direction (
  input  hrgd_pkg::axis_t x_axis,
  input  hrgd_pkg::axis_t y_axis,
  output logic [2:0]      key
);

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [32:0]        dx_mag;
  logic [32:0]        dy_mag;
  logic               x_zero;
  logic               y_zero;

  // Exact deltas at 33 bits
  assign dx = {x_axis.latest[31], x_axis.latest} - {x_axis.previous[31], x_axis.previous};
  assign dy = {y_axis.latest[31], y_axis.latest} - {y_axis.previous[31], y_axis.previous};
  assign dx_mag = dx[32] ? 33'(-dx) : 33'(dx);
  assign dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
  assign x_zero = (x_axis.latest == 32'sd0);
  assign y_zero = (y_axis.latest == 32'sd0);

  always_comb begin
    if (x_axis.seen < hrgd_pkg::SEEN_MAX && y_axis.seen < hrgd_pkg::SEEN_MAX) begin
      key = hrgd_pkg::KC_BUTTON;
    end else if (dx == 33'sd0 && dy == 33'sd0) begin
      // No motion: fall back to the sign of a lone nonzero coordinate
      if (x_zero == y_zero) begin
        key = hrgd_pkg::KC_UNKNOWN;
      end else if (!x_zero) begin
        key = x_axis.latest[31] ? hrgd_pkg::KC_RIGHT : hrgd_pkg::KC_LEFT;
      end else begin
        key = y_axis.latest[31] ? hrgd_pkg::KC_DOWN : hrgd_pkg::KC_UP;
      end
    end else if (dx_mag > dy_mag) begin
      key = dx[32] ? hrgd_pkg::KC_LEFT : hrgd_pkg::KC_RIGHT;
    end else begin
      key = dy[32] ? hrgd_pkg::KC_UP : hrgd_pkg::KC_DOWN;
    end
  end

endmodule

>>> rtl/hid_remote_gesture_decoder.sv
// Top level of the HID remote gesture decoder.
`timescale 1ns / 1ps

// Decodes a stream of HID usage events from a remote into key codes. Each input
// transaction carries one event (usage page, usage code, signed value and a
// 64-bit microsecond timestamp); an event produces zero or one output key.
// Volume up/down presses on the consumer page give the shutter key; a button,
// tip-switch or in-range press and release bracket a swipe whose direction is
// taken from the last two desktop X/Y reports. Keys that fall within
// debounce_window_us of the last emitted key are dropped. Throughput is one
// event per clock while the output does not stall: an event is held in the
// input register, and the debounce subtract/compare plus the direction
// decision settle combinationally before the result register. Events pass
// through the input and result registers. The user writes the debounce window
// through cfg_we/cfg_wdata only while idle; the block does not enforce this.
module hid_remote_gesture_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [23:0]  cfg_wdata,       // debounce_window_us
  input  logic         s_tvalid,
  output logic         s_tready,
  // page[15:0], usage_code[31:16], event_value[63:32], time_us[127:64]
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata          // key_code[2:0], zero fill above
);

  // Configuration
  logic [23:0] debounce_window;

  // Input register
  logic               in_valid;
  logic [15:0]        in_page;
  logic [15:0]        in_code;
  logic signed [31:0] in_value;
  logic [63:0]        in_time;

  // Decoder state
  logic            moving;
  hrgd_pkg::axis_t x_axis;
  hrgd_pkg::axis_t y_axis;
  logic [63:0]     last_key_time;

  // Result register
  logic [2:0] key_reg;

  // Stage control and decode
  logic        advance;
  logic        is_x;
  logic        is_y;
  logic        is_shutter;
  logic        is_swipe;
  logic        swipe_start;
  logic        swipe_end;
  logic [63:0] elapsed;
  logic        window_open;
  logic        fire;
  logic [2:0]  swipe_key;
  logic        moving_next;
  hrgd_pkg::axis_t x_axis_next;
  hrgd_pkg::axis_t y_axis_next;

  // Advance the stage only when the result register can take a key
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_window <= hrgd_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_window <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_page  <= s_tdata[15:0];
      in_code  <= s_tdata[31:16];
      in_value <= $signed(s_tdata[63:32]);
      in_time  <= s_tdata[127:64];
    end
  end

  // Event classification
  assign is_x = (in_page == hrgd_pkg::PAGE_DESKTOP) && (in_code == hrgd_pkg::DESK_X);
  assign is_y = (in_page == hrgd_pkg::PAGE_DESKTOP) && (in_code == hrgd_pkg::DESK_Y);
  assign is_shutter = (in_value == 32'sd1) && (in_page == hrgd_pkg::PAGE_CONSUMER) &&
                      ((in_code == hrgd_pkg::CONS_VOL_UP) ||
                       (in_code == hrgd_pkg::CONS_VOL_DOWN));
  assign is_swipe = ((in_page == hrgd_pkg::PAGE_BUTTON) &&
                     (in_code == hrgd_pkg::BTN_PRIMARY)) ||
                    ((in_page == hrgd_pkg::PAGE_DIGITIZER) &&
                     ((in_code == hrgd_pkg::DIG_TIP) ||
                      (in_code == hrgd_pkg::DIG_IN_RANGE)));
  assign swipe_start = !is_shutter && !moving && (in_value == 32'sd1) && is_swipe;
  assign swipe_end   = !is_shutter && moving && (in_value == 32'sd0) && is_swipe;

  // Debounce: elapsed time wraps modulo 2^64
  assign elapsed     = in_time - last_key_time;
  assign window_open = (elapsed >= {40'd0, debounce_window});
  assign fire        = advance && (is_shutter || swipe_end) && window_open;

  hrgd_direction u_direction (
    .x_axis (x_axis),
    .y_axis (y_axis),
    .key    (swipe_key)
  );

  // Next state of the axis history and swipe flag
  always_comb begin
    x_axis_next = x_axis;
    y_axis_next = y_axis;
    moving_next = moving;
    if (is_x) begin
      x_axis_next.previous = x_axis.latest;
      x_axis_next.latest   = in_value;
      if (x_axis.seen < hrgd_pkg::SEEN_MAX) begin
        x_axis_next.seen = x_axis.seen + 2'd1;
      end
    end
    if (is_y) begin
      y_axis_next.previous = y_axis.latest;
      y_axis_next.latest   = in_value;
      if (y_axis.seen < hrgd_pkg::SEEN_MAX) begin
        y_axis_next.seen = y_axis.seen + 2'd1;
      end
    end
    if (swipe_start) begin
      // Clear the counts only; stored values are kept
      moving_next      = 1'b1;
      x_axis_next.seen = 2'd0;
      y_axis_next.seen = 2'd0;
    end
    if (swipe_end) begin
      moving_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moving        <= 1'b0;
      x_axis        <= '0;
      y_axis        <= '0;
      last_key_time <= 64'd0;
    end else if (advance) begin
      moving <= moving_next;
      x_axis <= x_axis_next;
      y_axis <= y_axis_next;
      if (fire) begin
        last_key_time <= in_time;
      end
    end
  end

  // Result register: load on a key, drop valid once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      key_reg <= is_shutter ? hrgd_pkg::KC_SHUTTER : swipe_key;
    end
  end

  assign m_tdata = {5'd0, key_reg};

  // A stalled event must stay in the input register
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_time))
    else $error("input stage lost a stalled event");

  // An emitted key records its timestamp for the debounce
  a_key_time: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid && last_key_time == $past(in_time))
    else $error("emitted key did not update last key time");

  // A swipe start clears both seen counts and sets the swipe flag
  a_swipe_start: assert property (@(posedge clk) disable iff (rst)
    advance && swipe_start |=> moving && x_axis.seen == 2'd0 && y_axis.seen == 2'd0)
    else $error("swipe start did not clear the axis counts");

  // Seen counts saturate
  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    x_axis.seen <= hrgd_pkg::SEEN_MAX && y_axis.seen <= hrgd_pkg::SEEN_MAX)
    else $error("axis seen count above saturation");

endmodule
